/* design/sbfe_pkg.sv */
package sbfe_pkg;

    localparam int NUM_LANES = 2;
    localparam int LANE_LEFT = 0;
    localparam int LANE_RIGHT = 1;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W = 17;
    localparam int WORD_W = 32;
    localparam int CELL_W = 16;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h10000;

    typedef enum logic
    {
        REG_VOLUME_GAIN = 1'b0,
        REG_MONO_MODE = 1'b1
    } reg_index_t;

    localparam logic [CELL_W-1:0] PRE_B = 16'hCCE8;
    localparam logic [CELL_W-1:0] PRE_M = 16'hCCE2;
    localparam logic [CELL_W-1:0] PRE_W = 16'hCCE4;
    localparam logic [CELL_W-1:0] AUX_BASE = 16'hB333;
    localparam logic [CELL_W-1:0] AUX_FLIP = 16'h7FFF;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic block_restart;
        logic last_in_buffer;
    } sample_t;

    typedef struct packed
    {
        logic [WORD_W-1:0] left_data_word;
        logic [WORD_W-1:0] left_status_word;
        logic [WORD_W-1:0] right_data_word;
        logic [WORD_W-1:0] right_status_word;
        logic last_out;
    } frame_t;

    typedef struct packed
    {
        logic [WORD_W-1:0] data_word;
        logic [CELL_W-1:0] aux_cells;
    } lane_res_t;

    localparam logic [CELL_W-1:0] BMC_ROM [256] = '{
        16'hcccc, 16'h4ccc, 16'h2ccc, 16'haccc, 16'h34cc, 16'hb4cc, 16'hd4cc, 16'h54cc,
        16'h32cc, 16'hb2cc, 16'hd2cc, 16'h52cc, 16'hcacc, 16'h4acc, 16'h2acc, 16'haacc,
        16'h334c, 16'hb34c, 16'hd34c, 16'h534c, 16'hcb4c, 16'h4b4c, 16'h2b4c, 16'hab4c,
        16'hcd4c, 16'h4d4c, 16'h2d4c, 16'had4c, 16'h354c, 16'hb54c, 16'hd54c, 16'h554c,
        16'h332c, 16'hb32c, 16'hd32c, 16'h532c, 16'hcb2c, 16'h4b2c, 16'h2b2c, 16'hab2c,
        16'hcd2c, 16'h4d2c, 16'h2d2c, 16'had2c, 16'h352c, 16'hb52c, 16'hd52c, 16'h552c,
        16'hccac, 16'h4cac, 16'h2cac, 16'hacac, 16'h34ac, 16'hb4ac, 16'hd4ac, 16'h54ac,
        16'h32ac, 16'hb2ac, 16'hd2ac, 16'h52ac, 16'hcaac, 16'h4aac, 16'h2aac, 16'haaac,
        16'h3334, 16'hb334, 16'hd334, 16'h5334, 16'hcb34, 16'h4b34, 16'h2b34, 16'hab34,
        16'hcd34, 16'h4d34, 16'h2d34, 16'had34, 16'h3534, 16'hb534, 16'hd534, 16'h5534,
        16'hccb4, 16'h4cb4, 16'h2cb4, 16'hacb4, 16'h34b4, 16'hb4b4, 16'hd4b4, 16'h54b4,
        16'h32b4, 16'hb2b4, 16'hd2b4, 16'h52b4, 16'hcab4, 16'h4ab4, 16'h2ab4, 16'haab4,
        16'hccd4, 16'h4cd4, 16'h2cd4, 16'hacd4, 16'h34d4, 16'hb4d4, 16'hd4d4, 16'h54d4,
        16'h32d4, 16'hb2d4, 16'hd2d4, 16'h52d4, 16'hcad4, 16'h4ad4, 16'h2ad4, 16'haad4,
        16'h3354, 16'hb354, 16'hd354, 16'h5354, 16'hcb54, 16'h4b54, 16'h2b54, 16'hab54,
        16'hcd54, 16'h4d54, 16'h2d54, 16'had54, 16'h3554, 16'hb554, 16'hd554, 16'h5554,
        16'h3332, 16'hb332, 16'hd332, 16'h5332, 16'hcb32, 16'h4b32, 16'h2b32, 16'hab32,
        16'hcd32, 16'h4d32, 16'h2d32, 16'had32, 16'h3532, 16'hb532, 16'hd532, 16'h5532,
        16'hccb2, 16'h4cb2, 16'h2cb2, 16'hacb2, 16'h34b2, 16'hb4b2, 16'hd4b2, 16'h54b2,
        16'h32b2, 16'hb2b2, 16'hd2b2, 16'h52b2, 16'hcab2, 16'h4ab2, 16'h2ab2, 16'haab2,
        16'hccd2, 16'h4cd2, 16'h2cd2, 16'hacd2, 16'h34d2, 16'hb4d2, 16'hd4d2, 16'h54d2,
        16'h32d2, 16'hb2d2, 16'hd2d2, 16'h52d2, 16'hcad2, 16'h4ad2, 16'h2ad2, 16'haad2,
        16'h3352, 16'hb352, 16'hd352, 16'h5352, 16'hcb52, 16'h4b52, 16'h2b52, 16'hab52,
        16'hcd52, 16'h4d52, 16'h2d52, 16'had52, 16'h3552, 16'hb552, 16'hd552, 16'h5552,
        16'hccca, 16'h4cca, 16'h2cca, 16'hacca, 16'h34ca, 16'hb4ca, 16'hd4ca, 16'h54ca,
        16'h32ca, 16'hb2ca, 16'hd2ca, 16'h52ca, 16'hcaca, 16'h4aca, 16'h2aca, 16'haaca,
        16'h334a, 16'hb34a, 16'hd34a, 16'h534a, 16'hcb4a, 16'h4b4a, 16'h2b4a, 16'hab4a,
        16'hcd4a, 16'h4d4a, 16'h2d4a, 16'had4a, 16'h354a, 16'hb54a, 16'hd54a, 16'h554a,
        16'h332a, 16'hb32a, 16'hd32a, 16'h532a, 16'hcb2a, 16'h4b2a, 16'h2b2a, 16'hab2a,
        16'hcd2a, 16'h4d2a, 16'h2d2a, 16'had2a, 16'h352a, 16'hb52a, 16'hd52a, 16'h552a,
        16'hccaa, 16'h4caa, 16'h2caa, 16'hacaa, 16'h34aa, 16'hb4aa, 16'hd4aa, 16'h54aa,
        16'h32aa, 16'hb2aa, 16'hd2aa, 16'h52aa, 16'hcaaa, 16'h4aaa, 16'h2aaa, 16'haaaa
    };

endpackage

/* design/sbfe_lane.sv */
module sbfe_lane
(
    input  logic clk,
    input  logic load,
    input  logic signed [sbfe_pkg::SAMPLE_W-1:0] sample,
    input  logic [sbfe_pkg::GAIN_W-1:0] gain,
    output sbfe_pkg::lane_res_t res
);

    logic signed [sbfe_pkg::SAMPLE_W+sbfe_pkg::GAIN_W:0] product;
    logic [sbfe_pkg::SAMPLE_W-1:0] scaled_next;
    logic [sbfe_pkg::SAMPLE_W-1:0] scaled_reg;
    logic [sbfe_pkg::CELL_W-1:0] hi_cells;
    logic [sbfe_pkg::CELL_W-1:0] lo_cells;

    // The scaled sample is bits 31..16 of the signed product.
    assign product = sample * $signed({1'b0, gain});
    assign scaled_next = product[31:16];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scaled_reg <= scaled_next;
        end
    end

    // Low-byte cells are inverted when hi_cells[15] is 0, to keep the stream in phase.
    always_comb
    begin
        hi_cells = sbfe_pkg::BMC_ROM[scaled_reg[15:8]];
        lo_cells = sbfe_pkg::BMC_ROM[scaled_reg[7:0]];
        if (!hi_cells[15])
        begin
            lo_cells = ~lo_cells;
        end
        res.data_word = {lo_cells, hi_cells};
        res.aux_cells = lo_cells[15] ? (sbfe_pkg::AUX_BASE ^ sbfe_pkg::AUX_FLIP)
                                     : sbfe_pkg::AUX_BASE;
    end

endmodule

/* design/sbfe_merge.sv */
module sbfe_merge
(
    input  logic clk,
    input  logic load,
    input  sbfe_pkg::lane_res_t lane_res [sbfe_pkg::NUM_LANES],
    input  logic block_start,
    input  logic last_in_buffer,
    output sbfe_pkg::frame_t frame
);

    sbfe_pkg::frame_t frame_next;
    sbfe_pkg::frame_t frame_reg;

    always_comb
    begin
        frame_next.left_data_word = lane_res[sbfe_pkg::LANE_LEFT].data_word;
        frame_next.left_status_word =
            {(block_start ? sbfe_pkg::PRE_B : sbfe_pkg::PRE_M),
             lane_res[sbfe_pkg::LANE_LEFT].aux_cells};
        frame_next.right_data_word = lane_res[sbfe_pkg::LANE_RIGHT].data_word;
        frame_next.right_status_word =
            {sbfe_pkg::PRE_W, lane_res[sbfe_pkg::LANE_RIGHT].aux_cells};
        frame_next.last_out = last_in_buffer;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame = frame_reg;

endmodule

/* design/spdif_biphase_frame_encoder.sv */
// Encodes one stereo sample pair per request into an S/PDIF frame of two biphase-mark
// subframes. A new pair can be taken every clock cycle while the frame side is not stalling.
// A pair first sits in the lane registers that hold the scaled samples, and their ROM
// lookup feeds the output register; it then sits in that output register. Stalls on
// the frame side propagate back one stage at a time, so an empty stage keeps taking
// requests while a frame waits. Write volume_gain and mono_mode only while no request
// is in flight.
module spdif_biphase_frame_encoder
#(
    parameter int FRAMES_PER_BLOCK = 192
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic sample_valid,
    output logic sample_stall,
    input  sbfe_pkg::sample_t sample,
    output logic frame_valid,
    input  logic frame_stall,
    output sbfe_pkg::frame_t frame,
    input  logic cfg_we,
    input  sbfe_pkg::reg_index_t cfg_index,
    input  logic [sbfe_pkg::GAIN_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(FRAMES_PER_BLOCK);

    logic [sbfe_pkg::GAIN_W-1:0] gain_reg;
    logic mono_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W:0] cnt_inc;
    logic s1_valid_reg;
    logic s1_first_reg;
    logic s1_last_reg;
    logic out_valid_reg;
    logic out_ready;
    logic s1_ready;
    logic sample_accept;
    logic first_next;
    logic signed [sbfe_pkg::SAMPLE_W-1:0] lane_sample [sbfe_pkg::NUM_LANES];
    sbfe_pkg::lane_res_t lane_res [sbfe_pkg::NUM_LANES];

    assign out_ready = !out_valid_reg || !frame_stall;
    assign s1_ready = !s1_valid_reg || out_ready;
    assign sample_stall = !s1_ready;
    assign sample_accept = sample_valid && s1_ready;
    assign frame_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= sbfe_pkg::GAIN_UNITY;
            mono_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sbfe_pkg::REG_VOLUME_GAIN: gain_reg <= cfg_data;
                sbfe_pkg::REG_MONO_MODE: mono_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A restart request counts as frame zero of a new block.
    always_comb
    begin
        first_next = sample.block_restart || (cnt_reg == '0);
        cnt_inc = (sample.block_restart ? '0 : (CNT_W + 1)'(cnt_reg)) + (CNT_W + 1)'(1);
        if (cnt_inc >= (CNT_W + 1)'(FRAMES_PER_BLOCK))
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_accept)
            begin
                cnt_reg <= cnt_next;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_first_reg <= first_next;
            s1_last_reg <= sample.last_in_buffer;
        end
    end

    assign lane_sample[sbfe_pkg::LANE_LEFT] = sample.left_sample;
    assign lane_sample[sbfe_pkg::LANE_RIGHT] = mono_reg ? sample.left_sample
                                                        : sample.right_sample;

    for (genvar i = 0; i < sbfe_pkg::NUM_LANES; i++)
    begin : g_lane
        sbfe_lane u_lane
        (
            .clk(clk),
            .load(sample_accept),
            .sample(lane_sample[i]),
            .gain(gain_reg),
            .res(lane_res[i])
        );
    end

    sbfe_merge u_merge
    (
        .clk(clk),
        .load(out_ready && s1_valid_reg),
        .lane_res(lane_res),
        .block_start(s1_first_reg),
        .last_in_buffer(s1_last_reg),
        .frame(frame)
    );

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(cnt_reg) < (CNT_W + 1)'(FRAMES_PER_BLOCK))
        else $error("frame counter out of range");

    a_restart_first: assert property (@(posedge clk) disable iff (!rst_n)
        sample_accept && sample.block_restart |=> s1_valid_reg && s1_first_reg)
        else $error("restart pair not marked as block start");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_stall && !s1_valid_reg |=> !frame_valid)
        else $error("frame repeated after it was taken");

    a_right_preamble: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> frame.right_status_word[31:16] == sbfe_pkg::PRE_W)
        else $error("right subframe preamble is not W");

endmodule
